// File: rtl/sai_pkg.sv
package sai_pkg;

   // store geometry
   localparam int DEPTH  = 64;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // field widths
   localparam int VALUE_W  = 32;
   localparam int CAP_W    = 7;
   localparam int STATUS_W = 2;
   localparam int ECOUNT_W = 7;
   localparam int CMP_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   // packed beat widths
   localparam int REQ_DATA_W = 32;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 16;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE     = 2'd0,
      ST_FULL     = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   // datapath actions issued by the controller
   typedef enum logic [3:0] {
      DP_NONE      = 4'd0,
      DP_INS_FIRST = 4'd1,
      DP_INS_START = 4'd2,
      DP_INS_SHIFT = 4'd3,
      DP_INS_PUT   = 4'd4,
      DP_DEL_START = 4'd5,
      DP_SCAN_NEXT = 4'd6,
      DP_SCAN_HIT  = 4'd7,
      DP_DEL_SHIFT = 4'd8
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic       set_status;
      status_type status;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic req_op;
      logic full;
      logic empty;
      logic gt;
      logic eq;
      logic idx_is_one;
      logic scan_more;
      logic shift_last;
      logic rsp_free;
   } dp_status_type;

endpackage

// File: rtl/sorted_array_insert_delete_unit.sv
// channel   direction  beat contents (lowest bit first)
// req       in         tdata: value[31:0]; tuser: operation[0] (0 insert, 1 delete)
// rsp       out        tdata: status[1:0], entry_count[8:2], is_full[9], is_empty[10]
// csr       in         wdata: capacity_in_use[6:0]
//
// insert moves the larger entries up one by one, delete scans to the match and then moves
// the later entries down one by one; a refusal or an insert into an empty list moves none
// the steps are set by the one read and one write port of the store
// reset empties the list and sets capacity to 64; the store is not cleared
// a result waits in its output register until rsp_tready; the next request is
// taken meanwhile, and an operation holds in its final state while the register is full
module sorted_array_insert_delete_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // req_tdata: value[31:0]
   input  logic [sai_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_tuser: operation[0]
   input  logic [sai_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // rsp_tdata: status[1:0], entry_count[8:2], is_full[9], is_empty[10], zeros[15:11]
   output logic [sai_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   // csr_wdata: capacity_in_use[6:0]
   input  logic [sai_pkg::CAP_W-1:0]     csr_wdata
);
   import sai_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type dp_st;

   // sequencer
   sai_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .dp_st      (dp_st),
      .cmd        (cmd)
   );

   // store, count and result register
   sai_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .dp_st      (dp_st),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

endmodule

// File: rtl/sai_ram.sv
module sai_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/sai_datapath.sv
module sai_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  sai_pkg::dp_cmd_type           cmd,
   output sai_pkg::dp_status_type        dp_st,
   // req_tdata: value[31:0]
   input  logic [sai_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_tuser: operation[0]
   input  logic [sai_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // rsp_tdata: status[1:0], entry_count[8:2], is_full[9], is_empty[10], zeros[15:11]
   output logic [sai_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sai_pkg::CAP_W-1:0]     csr_wdata
);
   import sai_pkg::*;

   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          idx_ff, idx_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   status_type                status_ff, status_in;
   logic [CAP_W-1:0]          cap_ff, cap_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;

   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [VALUE_W-1:0]   wr_data;
   logic [ADDR_W-1:0]    rd_addr;
   logic [VALUE_W-1:0]   rd_data;

   logic [CNT_W-1:0] cnt_m1, idx_m1, idx_m2, idx_p1, idx_p2;
   logic [CMP_W-1:0] cnt_wide, cap_wide, eff_cap;
   logic             full_now;

   // store
   sai_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // neighbor indexes
   assign cnt_m1 = count_ff - CNT_W'(1);
   assign idx_m1 = idx_ff - CNT_W'(1);
   assign idx_m2 = idx_ff - CNT_W'(2);
   assign idx_p1 = idx_ff + CNT_W'(1);
   assign idx_p2 = idx_ff + CNT_W'(2);

   // effective capacity and full flag
   assign cnt_wide = CMP_W'(count_ff);
   assign cap_wide = CMP_W'(cap_ff);
   assign eff_cap  = (cap_wide > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_wide;
   assign full_now = (cnt_wide >= eff_cap);

   // status to the controller
   always_comb begin
      dp_st.req_op     = req_tuser[0];
      dp_st.full       = full_now;
      dp_st.empty      = (count_ff == '0);
      dp_st.gt         = ($signed(rd_data) > value_ff);
      dp_st.eq         = (rd_data == value_ff);
      dp_st.idx_is_one = (idx_ff == CNT_W'(1));
      dp_st.scan_more  = (idx_p1 < count_ff);
      dp_st.shift_last = (idx_p2 >= count_ff);
      dp_st.rsp_free   = !rsp_valid_ff || rsp_tready;
   end

   // memory addressing and index update per action
   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = idx_ff[ADDR_W-1:0];
      wr_data  = rd_data;
      rd_addr  = idx_ff[ADDR_W-1:0];
      idx_in   = idx_ff;
      value_in = value_ff;
      unique case (cmd.op)
         DP_NONE: begin
         end
         DP_INS_FIRST: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = req_tdata[VALUE_W-1:0];
         end
         DP_INS_START: begin
            value_in = $signed(req_tdata[VALUE_W-1:0]);
            idx_in   = count_ff;
            rd_addr  = cnt_m1[ADDR_W-1:0];
         end
         DP_INS_SHIFT: begin
            wr_en   = 1'b1;
            wr_data = rd_data;
            idx_in  = idx_m1;
            rd_addr = idx_m2[ADDR_W-1:0];
         end
         DP_INS_PUT: begin
            wr_en   = 1'b1;
            wr_data = value_ff;
         end
         DP_DEL_START: begin
            value_in = $signed(req_tdata[VALUE_W-1:0]);
            idx_in   = '0;
            rd_addr  = '0;
         end
         DP_SCAN_NEXT: begin
            idx_in  = idx_p1;
            rd_addr = idx_p1[ADDR_W-1:0];
         end
         DP_SCAN_HIT: begin
            rd_addr = idx_p1[ADDR_W-1:0];
         end
         DP_DEL_SHIFT: begin
            wr_en   = 1'b1;
            wr_data = rd_data;
            idx_in  = idx_p1;
            rd_addr = idx_p2[ADDR_W-1:0];
         end
         default: begin
         end
      endcase
   end

   // count, status and capacity
   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = cnt_m1;
      end
      status_in = cmd.set_status ? cmd.status : status_ff;
      cap_in    = csr_valid ? csr_wdata : cap_ff;
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {5'b0, (count_ff == '0), full_now,
                         cnt_wide[ECOUNT_W-1:0], status_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      value_ff    <= value_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

endmodule

// File: rtl/sai_ctrl.sv
module sai_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  sai_pkg::dp_status_type dp_st,
   output sai_pkg::dp_cmd_type    cmd
);
   import sai_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE      = 6'b000001,
      S_INS_CMP   = 6'b000010,
      S_INS_PLACE = 6'b000100,
      S_DEL_SCAN  = 6'b001000,
      S_DEL_SHIFT = 6'b010000,
      S_DONE      = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   // sequencing of insert walk and delete scan/shift
   always_comb begin
      state_in       = state_ff;
      cmd.op         = DP_NONE;
      cmd.set_status = 1'b0;
      cmd.status     = ST_DONE;
      cmd.cnt_inc    = 1'b0;
      cmd.cnt_dec    = 1'b0;
      cmd.rsp_load   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (dp_st.req_op == OP_INSERT) begin
                  if (dp_st.full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_FULL;
                     state_in       = S_DONE;
                  end else if (dp_st.empty) begin
                     cmd.op         = DP_INS_FIRST;
                     cmd.set_status = 1'b1;
                     cmd.cnt_inc    = 1'b1;
                     state_in       = S_DONE;
                  end else begin
                     cmd.op   = DP_INS_START;
                     state_in = S_INS_CMP;
                  end
               end else begin
                  if (dp_st.empty) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_EMPTY;
                     state_in       = S_DONE;
                  end else begin
                     cmd.op   = DP_DEL_START;
                     state_in = S_DEL_SCAN;
                  end
               end
            end
         end
         S_INS_CMP: begin
            if (dp_st.gt) begin
               cmd.op = DP_INS_SHIFT;
               if (dp_st.idx_is_one) begin
                  state_in = S_INS_PLACE;
               end
            end else begin
               cmd.op         = DP_INS_PUT;
               cmd.set_status = 1'b1;
               cmd.cnt_inc    = 1'b1;
               state_in       = S_DONE;
            end
         end
         S_INS_PLACE: begin
            cmd.op         = DP_INS_PUT;
            cmd.set_status = 1'b1;
            cmd.cnt_inc    = 1'b1;
            state_in       = S_DONE;
         end
         S_DEL_SCAN: begin
            priority if (dp_st.eq && dp_st.scan_more) begin
               cmd.op   = DP_SCAN_HIT;
               state_in = S_DEL_SHIFT;
            end else if (dp_st.eq) begin
               cmd.set_status = 1'b1;
               cmd.cnt_dec    = 1'b1;
               state_in       = S_DONE;
            end else if (dp_st.scan_more) begin
               cmd.op = DP_SCAN_NEXT;
            end else begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_NOTFOUND;
               state_in       = S_DONE;
            end
         end
         S_DEL_SHIFT: begin
            cmd.op = DP_DEL_SHIFT;
            if (dp_st.shift_last) begin
               cmd.set_status = 1'b1;
               cmd.cnt_dec    = 1'b1;
               state_in       = S_DONE;
            end
         end
         S_DONE: begin
            if (dp_st.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: test/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import sai_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int LONG_HOLD   = 300;
   localparam int NUM_PHASES  = 11;

   typedef struct {
      logic               op;
      logic [VALUE_W-1:0] value;
   } list_request_type;

   typedef struct {
      status_type          status;
      logic [ECOUNT_W-1:0] count;
      logic                full;
      logic                empty;
   } list_reply_type;

   typedef enum {READY_ALWAYS, READY_HALF, READY_SLOW, READY_MOSTLY} ready_mode_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CAP_W-1:0]      csr_wdata  = '0;

   // mirror of the list and the capacity register
   logic [VALUE_W-1:0] list_model [DEPTH];
   int unsigned        list_size = 0;
   logic [CAP_W-1:0]   cap_model = CAP_RESET;

   list_request_type   request_queue [$];
   list_reply_type     pending_replies [$];
   logic [VALUE_W-1:0] value_pool [$];

   int             burst_left      = 1;
   int             gap_left        = 0;
   bit             sender_hold     = 1'b0;
   bit             long_hold_go    = 1'b0;
   bit             long_hold_done  = 1'b0;
   int             long_hold_count = 0;
   ready_mode_type ready_mode      = READY_ALWAYS;
   int             ready_mode_left = 0;
   int             mismatch_count  = 0;
   int             cycle_count     = 0;

   logic [CAP_W-1:0] phase_caps [NUM_PHASES] =
      '{7'd64, 7'd127, 7'd1, 7'd10, 7'd0, 7'd64, 7'd3, 7'd33, 7'd127, 7'd64, 7'd2};
   int phase_insert_pct [NUM_PHASES] = '{85, 60, 70, 60, 50, 30, 60, 75, 55, 20, 50};

   sorted_array_insert_delete_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sorted_array_insert_delete_unit verification failed");
         $finish;
      end
   end

   // apply one operation to the mirrored list and return the reply it gives
   function automatic list_reply_type apply_list_op(logic op, logic [VALUE_W-1:0] v);
      list_reply_type r;
      int unsigned    limit;
      int             pos;
      limit    = (cap_model > DEPTH) ? DEPTH : cap_model;
      r.status = ST_DONE;
      if (op == OP_INSERT) begin
         if (list_size >= limit || list_size >= DEPTH) begin
            r.status = ST_FULL;
         end else begin
            // larger entries move up, equal ones stay below the new value
            pos = list_size;
            while (pos > 0 && $signed(list_model[pos-1]) > $signed(v)) begin
               list_model[pos] = list_model[pos-1];
               pos--;
            end
            list_model[pos] = v;
            list_size++;
         end
      end else if (list_size == 0) begin
         r.status = ST_EMPTY;
      end else begin
         pos = 0;
         while (pos < list_size && list_model[pos] != v)
            pos++;
         if (pos == list_size) begin
            r.status = ST_NOTFOUND;
         end else begin
            for (int i = pos; i + 1 < list_size; i++)
               list_model[i] = list_model[i+1];
            list_size--;
         end
      end
      r.count = list_size[ECOUNT_W-1:0];
      r.full  = (list_size >= limit);
      r.empty = (list_size == 0);
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      mismatch_count++;
      if (mismatch_count <= 100)
         $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
   endtask

   task automatic queue_item(logic op, logic [VALUE_W-1:0] v);
      list_request_type it;
      it.op    = op;
      it.value = v;
      request_queue.push_back(it);
   endtask

   // random operations; deletes mostly aim at values inserted earlier
   task automatic queue_random_phase(int n, int insert_pct);
      logic [VALUE_W-1:0] v;
      logic               op;
      for (int k = 0; k < n; k++) begin
         op = ($urandom_range(1, 100) <= insert_pct) ? OP_INSERT : OP_DELETE;
         case ($urandom_range(0, 7))
            0, 1: v = $urandom_range(0, 16) - 8;
            2: begin
               case ($urandom_range(0, 3))
                  0: v = 32'h7FFF_FFFF;
                  1: v = 32'h8000_0000;
                  2: v = 32'hFFFF_FFFF;
                  default: v = 32'h0000_0000;
               endcase
            end
            default: v = $urandom;
         endcase
         if (op == OP_DELETE && value_pool.size() > 0 && $urandom_range(0, 9) < 7)
            v = value_pool[$urandom_range(0, value_pool.size() - 1)];
         if (op == OP_INSERT) begin
            value_pool.push_back(v);
            if (value_pool.size() > 2 * DEPTH)
               void'(value_pool.pop_front());
         end
         queue_item(op, v);
      end
   endtask

   // wait until every request is taken and every reply is in, checked between edges
   task automatic drain();
      do begin
         @(negedge clock);
      end while (request_queue.size() != 0 || req_tvalid || pending_replies.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_valid <= 1'b0;
      cap_model = v;
   endtask

   // request driver: bursts of beats with random gaps
   always @(posedge clock) begin
      list_request_type nxt;
      logic             taken;
      taken = req_tvalid && req_tready;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (taken)
            pending_replies.push_back(apply_list_op(req_tuser[0], req_tdata));
         if (!req_tvalid || taken) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (sender_hold || request_queue.size() == 0) begin
               req_tvalid <= 1'b0;
            end else begin
               nxt = request_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= nxt.value;
               req_tuser  <= nxt.op;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
               end else begin
                  burst_left--;
               end
            end
         end
      end
   end

   // reply monitor and receiver stall pattern
   always @(posedge clock) begin
      list_reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_replies.size() == 0) begin
            report_mismatch("reply beat with none pending, tdata", int'(rsp_tdata), -1);
         end else begin
            want = pending_replies.pop_front();
            if (rsp_tdata[1:0] != want.status)
               report_mismatch("status", int'(rsp_tdata[1:0]), int'(want.status));
            if (rsp_tdata[8:2] != want.count)
               report_mismatch("entry_count", int'(rsp_tdata[8:2]), int'(want.count));
            if (rsp_tdata[9] != want.full)
               report_mismatch("is_full", int'(rsp_tdata[9]), int'(want.full));
            if (rsp_tdata[10] != want.empty)
               report_mismatch("is_empty", int'(rsp_tdata[10]), int'(want.empty));
            if (rsp_tdata[15:11] != '0)
               report_mismatch("tdata padding", int'(rsp_tdata[15:11]), 0);
         end
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_hold_go && !long_hold_done) begin
         // long hold-off so the block backs up into the request side
         rsp_tready <= 1'b0;
         long_hold_count++;
         if (long_hold_count >= LONG_HOLD)
            long_hold_done = 1'b1;
      end else begin
         if (ready_mode_left == 0) begin
            ready_mode      = ready_mode_type'($urandom_range(0, 3));
            ready_mode_left = $urandom_range(10, 150);
         end else begin
            ready_mode_left--;
         end
         case (ready_mode)
            READY_ALWAYS: rsp_tready <= 1'b1;
            READY_HALF:   rsp_tready <= ($urandom_range(0, 1) == 1);
            READY_SLOW:   rsp_tready <= ($urandom_range(0, 4) == 0);
            default:      rsp_tready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty list, extremes, duplicates, not found
      queue_item(OP_DELETE, 32'd5);
      queue_item(OP_INSERT, 32'h7FFF_FFFF);
      queue_item(OP_INSERT, 32'h8000_0000);
      queue_item(OP_INSERT, 32'h0000_0000);
      queue_item(OP_INSERT, 32'hFFFF_FFFF);
      queue_item(OP_INSERT, 32'h0000_0000);
      queue_item(OP_INSERT, 32'h0000_0001);
      queue_item(OP_DELETE, 32'h0000_0007);
      queue_item(OP_DELETE, 32'h0000_0000);
      queue_item(OP_DELETE, 32'h8000_0000);
      queue_item(OP_DELETE, 32'h7FFF_FFFF);
      drain();

      // capacity lowered below the count: entries stay, inserts refused until deletes bring the count under it
      write_capacity(7'd2);
      queue_item(OP_INSERT, 32'd3);
      queue_item(OP_DELETE, 32'hFFFF_FFFF);
      queue_item(OP_DELETE, 32'h0000_0000);
      queue_item(OP_INSERT, 32'd5);
      drain();

      // capacity zero: full flag even when empty
      write_capacity(7'd0);
      queue_item(OP_INSERT, 32'd3);
      queue_item(OP_DELETE, 32'd1);
      queue_item(OP_DELETE, 32'd5);
      queue_item(OP_DELETE, 32'd5);
      queue_item(OP_INSERT, 32'd9);
      drain();

      // random phases, one capacity setting each
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_capacity(phase_caps[p]);
         queue_random_phase($urandom_range(85, 120), phase_insert_pct[p]);
         if (p == 3) begin
            long_hold_go = 1'b1;
            wait (long_hold_done);
         end
         if (p == 6) begin
            // sender stops mid-phase until all replies are back
            wait (request_queue.size() < 40);
            @(negedge clock);
            sender_hold = 1'b1;
            wait (!req_tvalid);
            wait (pending_replies.size() == 0);
            @(negedge clock);
            sender_hold = 1'b0;
         end
         drain();
      end

      repeat (DEPTH + 10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("sorted_array_insert_delete_unit verification clean");
      end else begin
         $display("sorted_array_insert_delete_unit verification failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/sai_pkg.sv
rtl/sai_ram.sv
rtl/sai_datapath.sv
rtl/sai_ctrl.sv
rtl/sorted_array_insert_delete_unit.sv
test/testbench.sv
